// File: design/text_cursor_glyph_streamer_macros.svh
// Assertion macros used by the text cursor glyph streamer byte sequencer.
`ifndef TEXT_CURSOR_GLYPH_STREAMER_MACROS_SVH
`define TEXT_CURSOR_GLYPH_STREAMER_MACROS_SVH

`ifndef ASSERT_OFF

// Check a property on every clock edge outside of reset.
`define TCGS_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define TCGS_ASSERT_ALWAYS(name, prop, msg) \
   name: assert property (@(posedge clock) prop) else $error(msg);

`else

`define TCGS_ASSERT(name, prop, msg)

`define TCGS_ASSERT_ALWAYS(name, prop, msg)

`endif

`endif

// File: design/tcgs_pkg.sv
// Types, constants and font table for the text cursor glyph streamer.
`default_nettype none

package tcgs_pkg;

   localparam int ROM_GLYPHS   = 101;
   localparam int ROM_WIDTH    = 6;
   localparam int COL_W        = 4;
   localparam int ROW_W        = 3;
   localparam int GLYPH_IDX_W  = 7;
   localparam int BYTE_SEL_W   = 3;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 8;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_WRAP_ENABLE = 2'd0,
      CSR_COLUMN_BASE = 2'd1,
      CSR_PAGE_BASE   = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic       wrap_enable;
      logic [7:0] column_command_base;
      logic [7:0] page_command_base;
   } cfg_type;

   // One character run handed from the front end to the byte sequencer.
   typedef struct packed {
      logic [7:0]             col_byte;
      logic [7:0]             page_byte;
      logic [GLYPH_IDX_W-1:0] glyph_idx;
      logic                   bad;
   } job_type;

   // Glyph columns, leftmost column in the top byte.
   localparam logic [47:0] GLYPH_ROM [ROM_GLYPHS] = '{
      48'h000000000000, 48'h0000004F0000, 48'h000007000700, 48'h00147F147F14,
      48'h00242A7F2A12, 48'h002313086462, 48'h003649552250, 48'h000005030000,
      48'h00001C224100, 48'h000041221C00, 48'h0014083E0814, 48'h0008083E0808,
      48'h000050300000, 48'h000808080808, 48'h000060600000, 48'h002010080402,
      48'h003E5149453E, 48'h0000427F4000, 48'h004261514946, 48'h002141454B31,
      48'h001814127F10, 48'h002745454539, 48'h003C4A494930, 48'h000171090503,
      48'h003649494936, 48'h00064949291E, 48'h000036360000, 48'h000056360000,
      48'h000814224100, 48'h001414141414, 48'h000041221408, 48'h000201510906,
      48'h00324979413E, 48'h007E1111117E, 48'h007F4949493E, 48'h003E41414122,
      48'h007F4141221C, 48'h007F49494941, 48'h007F09090901, 48'h003E4149497A,
      48'h007F0808087F, 48'h0000417F4100, 48'h002040413F01, 48'h007F08142241,
      48'h007F40404040, 48'h007F0204027F, 48'h007F0408107F, 48'h003E4141413E,
      48'h007F09090906, 48'h003E4151215E, 48'h007F09192946, 48'h004649494931,
      48'h0001017F0101, 48'h003F4040403F, 48'h001F2040201F, 48'h003F4038403F,
      48'h006314081463, 48'h000304780403, 48'h006151494543, 48'h00007F414100,
      48'h0015167C1615, 48'h000041417F00, 48'h000402010204, 48'h004040404040,
      48'h000001020400, 48'h002054545478, 48'h007F48444438, 48'h003844444420,
      48'h00384444487F, 48'h003854545418, 48'h00087E090102, 48'h000C5252523E,
      48'h007F08040478, 48'h0000447D4000, 48'h002040443D00, 48'h007F10284400,
      48'h0000417F4000, 48'h007E020C027C, 48'h007E0402027C, 48'h003844444438,
      48'h007C14141408, 48'h00081414187C, 48'h007C08040408, 48'h004854545420,
      48'h00043F444020, 48'h003C4040207C, 48'h001C2040201C, 48'h003C4030403C,
      48'h004428102844, 48'h000C5050503C, 48'h004464544C44, 48'h000008364100,
      48'h0000007F0000, 48'h000041360800, 48'h000804081008, 48'h0008082A1C08,
      48'h00081C2A0808, 48'h0004027F0204, 48'h0010207F2010, 48'h001C2A322A1C,
      48'h001C2244221C
   };

   function automatic logic [7:0] glyph_byte(input logic [GLYPH_IDX_W-1:0] idx,
                                             input logic [BYTE_SEL_W-1:0]  sel);
      logic [47:0] word;
      word = '0;
      if (32'(idx) < ROM_GLYPHS) begin
         word = GLYPH_ROM[idx];
      end
      return word[8*(ROM_WIDTH-1-32'(sel)) +: 8];
   endfunction

endpackage

`default_nettype wire

// File: design/text_cursor_glyph_streamer.sv
// Top level of the text cursor glyph streamer.
// Path: a character's first byte passes the queue, the sequencer job register and the
//   output register, waiting while the sequencer is busy or the output stalls.
// Throughput: the byte sequencer puts out one byte per cycle unless the output stalls.
// Reset: synchronous; clears cursor to column 0, row 0, empties the queue and loads
//   wrap on, column base 0x80 and page base 0x40.
`default_nettype none

module text_cursor_glyph_streamer
   import tcgs_pkg::*;
#(
   parameter int GLYPH_WIDTH  = 6,
   parameter int TEXT_COLUMNS = 14,
   parameter int TEXT_ROWS    = 6,
   parameter int FIRST_CODE   = 32
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // item input
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic                   req_opcode,
   input  wire logic [COL_W-1:0]       req_text_column,
   input  wire logic [ROW_W-1:0]       req_text_row,
   input  wire logic [7:0]             req_char_code,
   // byte output
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic [7:0]                  rsp_out_byte,
   output logic                        rsp_is_data,
   output logic                        rsp_last_of_char,
   output logic                        rsp_bad_code,
   // register writes
   input  wire logic                   csr_write_enable,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_write_data
);

   cfg_type cfg_ff, cfg_in;

   logic    push;
   job_type push_job;
   logic    full;
   logic    pop;
   job_type pop_job;
   logic    empty;

   // Register writes land here; an unknown index changes nothing.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_WRAP_ENABLE: cfg_in.wrap_enable         = csr_write_data[0];
            CSR_COLUMN_BASE: cfg_in.column_command_base = csr_write_data;
            CSR_PAGE_BASE:   cfg_in.page_command_base   = csr_write_data;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.wrap_enable         <= 1'b1;
         cfg_ff.column_command_base <= 8'h80;
         cfg_ff.page_command_base   <= 8'h40;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front end: takes items while the queue is not full, updates the cursor, queues character runs.
   // Dropped characters (no wrap, cursor past the last column) never enter the queue.
   tcgs_front #(
      .GLYPH_WIDTH  (GLYPH_WIDTH),
      .TEXT_COLUMNS (TEXT_COLUMNS),
      .TEXT_ROWS    (TEXT_ROWS),
      .FIRST_CODE   (FIRST_CODE)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_opcode      (req_opcode),
      .req_text_column (req_text_column),
      .req_text_row    (req_text_row),
      .req_char_code   (req_char_code),
      .cfg             (cfg_ff),
      .push            (push),
      .push_job        (push_job),
      .full            (full)
   );

   // Two runs of slack so the front keeps taking items while bytes drain.
   tcgs_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .full     (full),
      .pop      (pop),
      .pop_job  (pop_job),
      .empty    (empty)
   );

   // Sequencer: column command, page command, then the glyph bytes, one per cycle unless the output stalls.
   tcgs_back #(
      .GLYPH_WIDTH (GLYPH_WIDTH)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .empty            (empty),
      .pop_job          (pop_job),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_is_data      (rsp_is_data),
      .rsp_last_of_char (rsp_last_of_char),
      .rsp_bad_code     (rsp_bad_code)
   );

endmodule

`default_nettype wire

// File: design/tcgs_front.sv
// Front end: accepts items, keeps the text cursor and classifies characters.
`default_nettype none

module tcgs_front
   import tcgs_pkg::*;
#(
   parameter int GLYPH_WIDTH  = 6,
   parameter int TEXT_COLUMNS = 14,
   parameter int TEXT_ROWS    = 6,
   parameter int FIRST_CODE   = 32
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire logic             req_opcode,
   input  wire logic [COL_W-1:0] req_text_column,
   input  wire logic [ROW_W-1:0] req_text_row,
   input  wire logic [7:0]       req_char_code,
   input  wire cfg_type          cfg,
   output logic                  push,
   output job_type               push_job,
   input  wire logic             full
);

   localparam logic [COL_W:0]   COLS      = (COL_W+1)'(TEXT_COLUMNS);
   localparam logic [ROW_W:0]   ROWS      = (ROW_W+1)'(TEXT_ROWS);
   localparam logic [COL_W-1:0] COL_MAX   = COL_W'(TEXT_COLUMNS - 1);
   localparam logic [ROW_W-1:0] ROW_MAX   = ROW_W'(TEXT_ROWS - 1);
   localparam logic [COL_W-1:0] COL_LIMIT = '1;

   logic [COL_W-1:0] cursor_column_ff, cursor_column_in;
   logic [ROW_W-1:0] cursor_row_ff, cursor_row_in;

   logic             accept;
   logic             pending;
   logic             drop;
   logic [COL_W-1:0] eff_col;
   logic [ROW_W-1:0] eff_row;
   logic [ROW_W-1:0] row_after;
   logic [ROW_W-1:0] eff_row_after;
   logic [8:0]       code_off;
   logic             in_font;

   assign req_stall = full;
   assign accept    = req_valid && !req_stall;

   assign pending = {1'b0, cursor_column_ff} >= COLS;
   assign drop    = pending && !cfg.wrap_enable;

   assign row_after = (({1'b0, cursor_row_ff} + 1'b1) >= ROWS) ? '0 : cursor_row_ff + 1'b1;

   // Resolve a pending overflow: move to column 0 of the next row first.
   assign eff_col = pending ? '0 : cursor_column_ff;
   assign eff_row = pending ? row_after : cursor_row_ff;

   assign eff_row_after = (({1'b0, eff_row} + 1'b1) >= ROWS) ? '0 : eff_row + 1'b1;

   assign code_off = {1'b0, req_char_code} - 9'(FIRST_CODE);
   assign in_font  = ({1'b0, req_char_code} >= 9'(FIRST_CODE)) && (code_off < 9'(ROM_GLYPHS));

   always_comb begin
      push_job.col_byte  = 8'(eff_col * GLYPH_WIDTH) | cfg.column_command_base;
      push_job.page_byte = {5'b0, eff_row} | cfg.page_command_base;
      push_job.glyph_idx = in_font ? code_off[GLYPH_IDX_W-1:0] : '0;
      push_job.bad       = !in_font;
   end

   assign push = accept && req_opcode && !drop;

   always_comb begin
      cursor_column_in = cursor_column_ff;
      cursor_row_in    = cursor_row_ff;
      if (accept) begin
         if (!req_opcode) begin
            cursor_column_in = ({1'b0, req_text_column} >= COLS) ? COL_MAX : req_text_column;
            cursor_row_in    = ({1'b0, req_text_row} >= ROWS) ? ROW_MAX : req_text_row;
         end else if (!drop) begin
            cursor_row_in = eff_row;
            if (({1'b0, eff_col} + 1'b1) >= COLS) begin
               if (cfg.wrap_enable) begin
                  cursor_column_in = '0;
                  cursor_row_in    = eff_row_after;
               end else if (eff_col < COL_LIMIT) begin
                  cursor_column_in = eff_col + 1'b1;
               end else begin
                  cursor_column_in = eff_col;
               end
            end else begin
               cursor_column_in = eff_col + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_column_ff <= '0;
         cursor_row_ff    <= '0;
      end else begin
         cursor_column_ff <= cursor_column_in;
         cursor_row_ff    <= cursor_row_in;
      end
   end

endmodule

`default_nettype wire

// File: design/tcgs_queue.sv
// Two-entry queue of character runs between the front end and the sequencer.
`default_nettype none

module tcgs_queue
   import tcgs_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire job_type push_job,
   output logic         full,
   input  wire logic    pop,
   output job_type      pop_job,
   output logic         empty
);

   job_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full    = count_ff == 2'd2;
   assign empty   = count_ff == 2'd0;
   assign pop_job = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

// File: design/tcgs_back.sv
// Byte sequencer: expands one character run into command and glyph bytes.
`default_nettype none
`include "text_cursor_glyph_streamer_macros.svh"

module tcgs_back
   import tcgs_pkg::*;
#(
   parameter int GLYPH_WIDTH = 6
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    empty,
   input  wire job_type pop_job,
   output logic         pop,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output logic [7:0]   rsp_out_byte,
   output logic         rsp_is_data,
   output logic         rsp_last_of_char,
   output logic         rsp_bad_code
);

   localparam int                 STEP_W    = $clog2(GLYPH_WIDTH + 2);
   localparam logic [STEP_W-1:0]  LAST_STEP = STEP_W'(GLYPH_WIDTH + 1);
   localparam logic [STEP_W-1:0]  LAST_POS  = STEP_W'(GLYPH_WIDTH - 1);
   localparam logic [STEP_W-1:0]  STEP_PAGE = STEP_W'(1);
   localparam logic [STEP_W-1:0]  STEP_COL  = STEP_W'(0);

   logic              busy_ff, busy_in;
   logic [STEP_W-1:0] step_ff, step_in;
   job_type           job_ff, job_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        rsp_byte_ff, rsp_byte_in;
   logic              rsp_data_ff, rsp_data_in;
   logic              rsp_last_ff, rsp_last_in;
   logic              rsp_bad_ff;

   logic              load_ok;
   logic              emit;
   logic              finish;
   logic [STEP_W-1:0] pos;

   assign load_ok = !rsp_valid_ff || !rsp_stall;
   assign emit    = busy_ff && load_ok;
   assign finish  = emit && (step_ff == LAST_STEP);
   assign pop     = !empty && (!busy_ff || finish);
   assign pos     = step_ff - STEP_W'(2);

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      job_in  = job_ff;
      if (pop) begin
         busy_in = 1'b1;
         step_in = '0;
         job_in  = pop_job;
      end else if (finish) begin
         busy_in = 1'b0;
      end else if (emit) begin
         step_in = step_ff + 1'b1;
      end
   end

   // Pick the byte for the current step.
   always_comb begin
      rsp_byte_in = 8'h00;
      rsp_data_in = 1'b1;
      rsp_last_in = 1'b0;
      if (step_ff == STEP_COL) begin
         rsp_byte_in = job_ff.col_byte;
         rsp_data_in = 1'b0;
      end else if (step_ff == STEP_PAGE) begin
         rsp_byte_in = job_ff.page_byte;
         rsp_data_in = 1'b0;
      end else begin
         if (!job_ff.bad && (32'(pos) < ROM_WIDTH)) begin
            rsp_byte_in = glyph_byte(job_ff.glyph_idx, BYTE_SEL_W'(pos));
         end
         rsp_last_in = pos == LAST_POS;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (load_ok) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
      if (emit) begin
         rsp_byte_ff <= rsp_byte_in;
         rsp_data_ff <= rsp_data_in;
         rsp_last_ff <= rsp_last_in;
         rsp_bad_ff  <= job_ff.bad;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_byte     = rsp_byte_ff;
   assign rsp_is_data      = rsp_data_ff;
   assign rsp_last_of_char = rsp_last_ff;
   assign rsp_bad_code     = rsp_bad_ff;

   `TCGS_ASSERT(step_in_range, step_ff <= LAST_STEP, "sequencer step beyond last byte")
   `TCGS_ASSERT(last_is_data, rsp_valid_ff && rsp_last_ff |-> rsp_data_ff, "last byte not data")
   `TCGS_ASSERT_ALWAYS(reset_clears_out, reset |=> !rsp_valid_ff && !busy_ff, "reset left work")

endmodule

`default_nettype wire
